[rtl/core/dq_pkg.sv]
// Shared operation codes, status codes and field types for the deque.
package dq_pkg;

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int ID_W     = 32;
    localparam int VALUE_W  = 32;

    typedef logic [MODE_W-1:0]          dq_mode_t;
    typedef logic [STATUS_W-1:0]        dq_status_t;
    typedef logic [ID_W-1:0]            dq_id_t;
    typedef logic signed [VALUE_W-1:0]  dq_value_t;

    // operation codes
    localparam dq_mode_t MODE_PUSH_FRONT = 3'd0;
    localparam dq_mode_t MODE_PUSH_BACK  = 3'd1;
    localparam dq_mode_t MODE_POP_FRONT  = 3'd2;
    localparam dq_mode_t MODE_POP_BACK   = 3'd3;
    localparam dq_mode_t MODE_PEEK_FRONT = 3'd4;
    localparam dq_mode_t MODE_PEEK_BACK  = 3'd5;

    // result status codes
    localparam dq_status_t STATUS_OK    = 2'd0;
    localparam dq_status_t STATUS_EMPTY = 2'd1;
    localparam dq_status_t STATUS_FULL  = 2'd2;

endpackage

[rtl/core/dq_chan_if.sv]
// Valid/ready channel interfaces for deque requests and responses.
interface dq_req_if;
    logic             valid;
    logic             ready;
    dq_pkg::dq_mode_t  mode;
    dq_pkg::dq_value_t payload;

    modport source (output valid, output mode, output payload, input ready);
    modport sink   (input valid, input mode, input payload, output ready);
endinterface

interface dq_rsp_if #(
    parameter int OCC_W = 5
);
    logic               valid;
    logic               ready;
    dq_pkg::dq_status_t status;
    dq_pkg::dq_id_t     entry_id;
    dq_pkg::dq_value_t  entry_value;
    logic [OCC_W-1:0]   occupancy;

    modport source (output valid, output status, output entry_id, output entry_value,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input entry_id, input entry_value,
                    input occupancy, output ready);
endinterface

[rtl/core/double_ended_queue_top.sv]
// Bounded double-ended queue held in a ring of DEPTH entries in block memory.
//
// Channels: req carries one operation per item (mode, payload); rsp returns
// exactly one result item per request (status, entry_id, entry_value,
// occupancy after the operation). Each stored push takes the next id from
// a 32-bit counter that starts at 1 and wraps.
// Result path: a push, a rejected operation or an unused mode is loaded
// into the output register at the edge that accepts it. A pop or peek of a
// held entry first goes through the registered memory read: the entry goes
// into the read-data register, then into the output register.
// Throughput: pushes and error results run at 1 item per cycle while rsp
// is taken; after a pop or peek is accepted, req stays not ready until its
// read data from the synchronous read port of the entry memory has reached
// the output register.
// Reset: front pointer, count and id counter clear; the entry memory is not
// cleared, since only held entries are ever read.
// Stall: when rsp is not taken, the result holds in the output register and
// req stays not ready until that register is taken or freed in the same cycle.
module double_ended_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    dq_req_if.sink   req,
    dq_rsp_if.source rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 2;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // control state
    logic                state_reg, state_next;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    dq_pkg::dq_id_t      last_id_reg, last_id_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    dq_pkg::dq_status_t  out_status_reg, out_status_next;
    dq_pkg::dq_id_t      out_id_reg, out_id_next;
    dq_pkg::dq_value_t   out_value_reg, out_value_next;
    logic [CNT_W-1:0]    out_occ_reg, out_occ_next;

    // entry memory and its registered read data
    dq_pkg::dq_value_t   value_mem [DEPTH];
    dq_pkg::dq_id_t      id_mem [DEPTH];
    dq_pkg::dq_value_t   rd_value_reg;
    dq_pkg::dq_id_t      rd_id_reg;

    logic                accept;
    logic                out_free;
    logic                is_full;
    logic                is_empty;
    logic [IDX_W-1:0]    front_dec;
    logic [IDX_W-1:0]    front_inc;
    logic [SUM_W-1:0]    tail_sum;
    logic [IDX_W-1:0]    tail_slot;
    logic [IDX_W-1:0]    back_slot;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_slot;
    dq_pkg::dq_id_t      wr_id;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_slot;

    // handshake
    assign out_free   = !out_valid_reg || rsp.ready;
    assign req.ready  = (state_reg == ST_IDLE) && out_free;
    assign accept     = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_id    = out_id_reg;
    assign rsp.entry_value = out_value_reg;
    assign rsp.occupancy   = out_occ_reg;

    // ring slot arithmetic and next push id
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign tail_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(tail_sum);
    assign back_slot = (tail_slot == '0) ? IDX_W'(DEPTH - 1) : tail_slot - 1'b1;
    assign wr_id     = last_id_reg + 1'b1;

    // operation decode and next state
    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        last_id_next    = last_id_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_value_next  = out_value_reg;
        out_occ_next    = out_occ_reg;
        wr_en           = 1'b0;
        wr_slot         = tail_slot;
        rd_en           = 1'b0;
        rd_slot         = front_reg;

        if (state_reg == ST_READ)
        begin
            // read data is back: present the held entry
            state_next      = ST_IDLE;
            out_valid_next  = 1'b1;
            out_status_next = dq_pkg::STATUS_OK;
            out_id_next     = rd_id_reg;
            out_value_next  = rd_value_reg;
            out_occ_next    = count_reg;
        end
        else if (accept)
        begin
            out_valid_next  = 1'b1;
            out_status_next = dq_pkg::STATUS_OK;
            out_id_next     = '0;
            out_value_next  = '0;
            out_occ_next    = count_reg;
            case (req.mode)
                dq_pkg::MODE_PUSH_FRONT,
                dq_pkg::MODE_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        out_status_next = dq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wr_en        = 1'b1;
                        wr_slot      = (req.mode == dq_pkg::MODE_PUSH_FRONT) ? front_dec
                                                                             : tail_slot;
                        if (req.mode == dq_pkg::MODE_PUSH_FRONT)
                        begin
                            front_next = front_dec;
                        end
                        last_id_next   = wr_id;
                        count_next     = count_reg + 1'b1;
                        out_id_next    = wr_id;
                        out_value_next = req.payload;
                        out_occ_next   = count_reg + 1'b1;
                    end
                end
                dq_pkg::MODE_POP_FRONT,
                dq_pkg::MODE_POP_BACK,
                dq_pkg::MODE_PEEK_FRONT,
                dq_pkg::MODE_PEEK_BACK:
                begin
                    if (is_empty)
                    begin
                        out_status_next = dq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        // result waits for the registered memory read
                        out_valid_next = 1'b0;
                        state_next     = ST_READ;
                        rd_en          = 1'b1;
                        rd_slot        = (req.mode == dq_pkg::MODE_POP_FRONT ||
                                          req.mode == dq_pkg::MODE_PEEK_FRONT) ? front_reg
                                                                               : back_slot;
                        if (req.mode == dq_pkg::MODE_POP_FRONT)
                        begin
                            front_next = front_inc;
                            count_next = count_reg - 1'b1;
                        end
                        else if (req.mode == dq_pkg::MODE_POP_BACK)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    // unused modes: no operation, zero result
                end
            endcase
        end
    end

    // control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            last_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            last_id_reg   <= last_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_value_reg  <= out_value_next;
        out_occ_reg    <= out_occ_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_slot] <= req.payload;
            id_mem[wr_slot]    <= wr_id;
        end
        if (rd_en)
        begin
            rd_value_reg <= value_mem[rd_slot];
            rd_id_reg    <= id_mem[rd_slot];
        end
    end

endmodule

[rtl/core/dq_checker.sv]
// Port-level assertions for the deque, bound to the top level.
module dq_checker #(
    parameter int DEPTH = 16,
    parameter int OCC_W = 5
) (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input dq_pkg::dq_status_t status,
    input dq_pkg::dq_id_t     entry_id,
    input dq_pkg::dq_value_t  entry_value,
    input logic [OCC_W-1:0]   occupancy
);

    // occupancy never goes past the ring size
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> occupancy <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    // a rejected push only happens on a full ring and carries no entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == dq_pkg::STATUS_FULL) |->
            (occupancy == OCC_W'(DEPTH) && entry_id == '0 && entry_value == '0))
        else $error("full status with bad fields");

    // empty status only on an empty ring and carries no entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == dq_pkg::STATUS_EMPTY) |->
            (occupancy == '0 && entry_id == '0 && entry_value == '0))
        else $error("empty status with bad fields");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(status) && $stable(entry_id) &&
             $stable(entry_value) && $stable(occupancy)))
        else $error("stalled result changed");

endmodule

bind double_ended_queue_top dq_checker #(
    .DEPTH (DEPTH),
    .OCC_W ($clog2(DEPTH + 1))
) u_dq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .entry_id    (rsp.entry_id),
    .entry_value (rsp.entry_value),
    .occupancy   (rsp.occupancy)
);
